@@ hdl/lsx_pkg.sv @@
// Package for the LED scanner with crossfade: sizes, register indexes, types,
// the tail intensity table and the speed table.
// No dependencies.
package lsx_pkg;

    localparam int LED_COUNT    = 25;
    localparam int TAIL_LENGTH  = 8;
    localparam int NUM_CH       = 3;

    localparam int IDX_W        = $clog2(LED_COUNT);
    localparam int POS_TOP      = (LED_COUNT - 1) * 256;
    localparam int POS_W        = $clog2(POS_TOP + 1);
    localparam int K_W          = POS_W - 4;
    localparam int TAIL_K_LIMIT = TAIL_LENGTH * 16;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam int SHOWN_W      = 16;
    localparam int BRIGHT_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BRT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_RATE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP        = 3'd6;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = BRIGHT_W'(60 * 256);

    // Intensity in 1/16 LED distance steps; every entry past the end is zero.
    localparam int TAIL_DEPTH = 112;
    localparam int TAIL_IDX_W = $clog2(TAIL_DEPTH);
    localparam logic [7:0] TAIL_TABLE [TAIL_DEPTH] = '{
        8'd255, 8'd242, 8'd228, 8'd216, 8'd204, 8'd192, 8'd182, 8'd171,
        8'd162, 8'd153, 8'd144, 8'd136, 8'd129, 8'd122, 8'd115, 8'd108,
        8'd102, 8'd97,  8'd91,  8'd86,  8'd81,  8'd77,  8'd73,  8'd69,
        8'd65,  8'd61,  8'd58,  8'd55,  8'd52,  8'd49,  8'd46,  8'd43,
        8'd41,  8'd39,  8'd37,  8'd34,  8'd33,  8'd31,  8'd29,  8'd27,
        8'd26,  8'd24,  8'd23,  8'd22,  8'd21,  8'd19,  8'd18,  8'd17,
        8'd16,  8'd15,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,
        8'd10,  8'd10,  8'd9,   8'd9,   8'd8,   8'd8,   8'd7,   8'd7,
        8'd7,   8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0
    };

    typedef struct packed {
        logic [NUM_CH-1:0][7:0] color;
        logic [2:0]             speed_level;
        logic [7:0]             target_brightness;
        logic [7:0]             fade_rate;
        logic                   flip;
    } t_cfg;

    typedef struct packed {
        logic             start_frame;
        logic             restart;
        logic             issue;
        logic [IDX_W-1:0] idx;
    } t_ctrl_cmd;

    typedef struct packed {
        logic advance;
        logic frame_done;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    function automatic logic [7:0] tail_level(input logic [K_W-1:0] k);
        logic [7:0] lvl;
        lvl = 8'd0;
        if (int'(k) < TAIL_K_LIMIT && int'(k) < TAIL_DEPTH) begin
            lvl = TAIL_TABLE[TAIL_IDX_W'(k)];
        end
        return lvl;
    endfunction

    // Out-of-range levels clamp to the nearest table end.
    function automatic logic [6:0] speed_step(input logic [2:0] lvl);
        logic [6:0] s;
        unique case (lvl) inside
            3'd0, 3'd1: s = 7'd15;
            3'd2:       s = 7'd31;
            3'd3:       s = 7'd46;
            3'd4:       s = 7'd64;
            default:    s = 7'd90;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/lsx_cfg_regs.sv @@
// Configuration register file of the LED scanner.
// Depends on lsx_pkg for the register indexes and the t_cfg type.
module lsx_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [lsx_pkg::CFG_IDX_W-1:0]      i_idx,
    input  logic [lsx_pkg::CFG_DATA_W-1:0]     i_wdata,
    output lsx_pkg::t_cfg                      o_cfg
);

    lsx_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color[0]          <= 8'd255;
            r_cfg.color[1]          <= 8'd10;
            r_cfg.color[2]          <= 8'd0;
            r_cfg.speed_level       <= 3'd3;
            r_cfg.target_brightness <= 8'd60;
            r_cfg.fade_rate         <= 8'd51;
            r_cfg.flip              <= 1'b0;
        end else if (i_we) begin
            unique case (i_idx)
                lsx_pkg::CFG_COLOR_RED:   r_cfg.color[0]          <= i_wdata;
                lsx_pkg::CFG_COLOR_GREEN: r_cfg.color[1]          <= i_wdata;
                lsx_pkg::CFG_COLOR_BLUE:  r_cfg.color[2]          <= i_wdata;
                lsx_pkg::CFG_SPEED_LEVEL: r_cfg.speed_level       <= i_wdata[2:0];
                lsx_pkg::CFG_TARGET_BRT:  r_cfg.target_brightness <= i_wdata;
                lsx_pkg::CFG_FADE_RATE:   r_cfg.fade_rate         <= i_wdata;
                lsx_pkg::CFG_FLIP:        r_cfg.flip              <= i_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/lsx_ctrl.sv @@
// Frame sequencer of the LED scanner: accepts a frame, issues LED indexes
// into the datapath pipeline and waits for the last pixel. Depends on lsx_pkg.
module lsx_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_restart,
    output logic                   o_in_ready,
    output lsx_pkg::t_ctrl_cmd     o_cmd,
    input  lsx_pkg::t_dp_status    i_status
);

    localparam logic [lsx_pkg::IDX_W-1:0] LAST_IDX = lsx_pkg::IDX_W'(lsx_pkg::LED_COUNT - 1);

    lsx_pkg::t_state r_state, n_state;
    logic [lsx_pkg::IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsx_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_idx             = r_idx;
        o_in_ready        = 1'b0;
        o_cmd.start_frame = 1'b0;
        o_cmd.restart     = i_restart;
        o_cmd.issue       = 1'b0;
        o_cmd.idx         = r_idx;
        unique case (r_state)
            lsx_pkg::ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.start_frame = i_in_valid;
                if (i_in_valid) begin
                    n_state = lsx_pkg::ST_SCAN;
                    n_idx   = '0;
                end
            end
            lsx_pkg::ST_SCAN: begin
                o_cmd.issue = i_status.advance;
                if (i_status.advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = lsx_pkg::ST_DRAIN;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            lsx_pkg::ST_DRAIN: begin
                if (i_status.frame_done) begin
                    n_state = lsx_pkg::ST_IDLE;
                end
            end
            default: n_state = lsx_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ hdl/lsx_dp.sv @@
// Datapath of the LED scanner: scanner position and brightness update, and a
// six-stage per-LED pipeline with the shown-color store. Depends on lsx_pkg.
module lsx_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsx_pkg::t_cfg          i_cfg,
    input  lsx_pkg::t_ctrl_cmd     i_cmd,
    output lsx_pkg::t_dp_status    o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [5:0]             o_led_index,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic                   o_last
);

    localparam int PW  = lsx_pkg::POS_W;
    localparam int IW  = lsx_pkg::IDX_W;
    localparam int SW  = lsx_pkg::SHOWN_W;
    localparam int BW  = lsx_pkg::BRIGHT_W;
    localparam int NCH = lsx_pkg::NUM_CH;
    localparam logic [IW-1:0] LAST_IDX = IW'(lsx_pkg::LED_COUNT - 1);

    // Frame-level state.
    logic [PW-1:0] r_pos, n_pos;
    logic          r_down, n_down;
    logic [BW-1:0] r_bright, n_bright;

    logic [PW-1:0] pos_cur, step;
    logic          down_cur;
    logic [PW:0]   up_sum;
    logic [BW-1:0] bright_goal, bright_diff;
    logic          bright_up;
    logic [BW+3:0] bright_scaled;

    always_comb begin
        pos_cur  = i_cmd.restart ? '0 : r_pos;
        down_cur = i_cmd.restart ? 1'b0 : r_down;
        step     = PW'(lsx_pkg::speed_step(i_cfg.speed_level));
        up_sum   = {1'b0, pos_cur} + {1'b0, step};
        if (down_cur) begin
            if (pos_cur <= step) begin
                n_pos  = '0;
                n_down = 1'b0;
            end else begin
                n_pos  = pos_cur - step;
                n_down = 1'b1;
            end
        end else begin
            if (up_sum >= (PW+1)'(lsx_pkg::POS_TOP)) begin
                n_pos  = PW'(lsx_pkg::POS_TOP);
                n_down = 1'b1;
            end else begin
                n_pos  = up_sum[PW-1:0];
                n_down = 1'b0;
            end
        end

        bright_goal   = {i_cfg.target_brightness, 8'h00};
        bright_up     = bright_goal >= r_bright;
        bright_diff   = bright_up ? bright_goal - r_bright : r_bright - bright_goal;
        bright_scaled = (BW+4)'(bright_diff * 4'd13) + (BW+4)'(128);
        n_bright      = bright_up ? r_bright + BW'(bright_scaled[BW+3:8])
                                  : r_bright - BW'(bright_scaled[BW+3:8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_down   <= 1'b0;
            r_bright <= lsx_pkg::BRIGHT_RESET;
        end else if (i_cmd.start_frame) begin
            r_pos    <= n_pos;
            r_down   <= n_down;
            r_bright <= n_bright;
        end
    end

    // The whole pipeline moves together whenever the output register is free.
    logic advance;
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r6_valid;

    logic [IW-1:0] r1_idx, r2_idx, r3_idx, r4_idx, r5_idx;
    logic [7:0]    r1_inten;
    logic [SW-1:0] r2_tgt   [NCH];
    logic [SW-1:0] r2_shown [NCH];
    logic [SW-1:0] r3_shown [NCH];
    logic [SW-1:0] r3_delta [NCH];
    logic          r3_up    [NCH];
    logic [SW-1:0] r4_shown [NCH];
    logic [31:0]   r5_prod  [NCH];
    logic [7:0]    r6_color [NCH];
    logic [5:0]    r6_led_index;
    logic          r6_last;

    // One entry per LED holds all three channels.
    logic [NCH-1:0][SW-1:0] r_shown [lsx_pkg::LED_COUNT];

    logic [PW-1:0]           here, span;
    logic [lsx_pkg::K_W-1:0] k;
    logic [SW-1:0]           fade_diff  [NCH];
    logic                    fade_up    [NCH];
    logic [SW+7:0]           fade_prod  [NCH];
    logic [SW-1:0]           n_shown    [NCH];
    logic [IW-1:0]           out_idx;

    assign advance = !r6_valid || i_out_ready;

    always_comb begin
        here = PW'({i_cmd.idx, 8'h00});
        span = (here >= r_pos) ? here - r_pos : r_pos - here;
        k    = span[PW-1:4];
        for (int ch = 0; ch < NCH; ch++) begin
            fade_up[ch]   = r2_tgt[ch] >= r2_shown[ch];
            fade_diff[ch] = fade_up[ch] ? r2_tgt[ch] - r2_shown[ch]
                                        : r2_shown[ch] - r2_tgt[ch];
            fade_prod[ch] = (SW+8)'(fade_diff[ch] * i_cfg.fade_rate) + (SW+8)'(128);
            n_shown[ch]   = r3_up[ch] ? r3_shown[ch] + r3_delta[ch]
                                      : r3_shown[ch] - r3_delta[ch];
        end
        out_idx = i_cfg.flip ? LAST_IDX - r5_idx : r5_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            for (int i = 0; i < lsx_pkg::LED_COUNT; i++) begin
                r_shown[i] <= '0;
            end
        end else if (advance) begin
            r1_valid <= i_cmd.issue;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            if (r3_valid) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    r_shown[r3_idx][ch] <= n_shown[ch];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_idx   <= i_cmd.idx;
            r1_inten <= lsx_pkg::tail_level(k);
            r2_idx   <= r1_idx;
            r3_idx   <= r2_idx;
            r4_idx   <= r3_idx;
            r5_idx   <= r4_idx;
            for (int ch = 0; ch < NCH; ch++) begin
                r2_tgt[ch]   <= i_cfg.color[ch] * r1_inten;
                r2_shown[ch] <= r_shown[r1_idx][ch];
                r3_up[ch]    <= fade_up[ch];
                r3_shown[ch] <= r2_shown[ch];
                r3_delta[ch] <= fade_prod[ch][SW+7:8];
                r4_shown[ch] <= n_shown[ch];
                r5_prod[ch]  <= r4_shown[ch] * r_bright;
                r6_color[ch] <= (r5_prod[ch][31:24] != 8'h00) ? 8'hFF : r5_prod[ch][23:16];
            end
            r6_led_index <= 6'(out_idx);
            r6_last      <= (r5_idx == LAST_IDX);
        end
    end

    assign o_out_valid         = r6_valid;
    assign o_led_index         = r6_led_index;
    assign o_red               = r6_color[0];
    assign o_green             = r6_color[1];
    assign o_blue              = r6_color[2];
    assign o_last              = r6_last;
    assign o_status.advance    = advance;
    assign o_status.frame_done = r6_valid && i_out_ready && r6_last;

endmodule

@@ hdl/led_scanner_crossfade.sv @@
// Bouncing LED scanner with fading tail, crossfade and smoothed brightness.
// One input transaction is one frame; it carries restart, which puts the
// scanner back to position zero moving upward before the frame's step.
// Each frame yields LED_COUNT output transactions, one pixel each in loop
// order, with led_index mirrored when flip is set and last on the final one.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata; the user
// must write it only while no frame is in flight, as the block itself does not
// enforce this. Unknown indexes are ignored. LED indexes of a frame enter a
// six-stage pipeline at one per cycle while the receiver does not stall, and
// walk through the shown-color store in loop order. A new frame is taken only
// after the last pixel of the previous frame has been accepted. A receiver
// stall freezes the whole pipeline; the pending pixel holds.
// Reset (synchronous, active low) restores the register defaults, puts the
// scanner at zero moving upward, brightness at 60 and all shown colors at
// zero, and empties the pipeline. Depends on lsx_pkg, lsx_cfg_regs, lsx_ctrl
// and lsx_dp.
module led_scanner_crossfade (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_restart,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [5:0]                         o_led_index,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic                               o_last,
    input  logic                               i_cfg_we,
    input  logic [lsx_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsx_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    lsx_pkg::t_cfg       cfg;
    lsx_pkg::t_ctrl_cmd  cmd;
    lsx_pkg::t_dp_status status;

    lsx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    lsx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_restart  (i_restart),
        .o_in_ready (o_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    lsx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_led_index (o_led_index),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_last      (o_last)
    );

endmodule

@@ hdl/lsx_checker.sv @@
// Port-level checks for the LED scanner, attached to the top level by bind.
// Depends on lsx_pkg and led_scanner_crossfade.
module lsx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [5:0] o_led_index,
    input logic [7:0] o_red,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_led_index) && $stable(o_red))
        else $error("stalled output transaction changed");

    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input still ready right after a frame was taken");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("pixel pending while the block takes a new frame");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |->
            (o_led_index == 6'd0 || o_led_index == 6'(lsx_pkg::LED_COUNT - 1)))
        else $error("last pixel is not at a strip end");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind led_scanner_crossfade lsx_checker u_lsx_checker (.*);

@@ tb/led_scanner_crossfade_test.sv @@
// Self-checking testbench for led_scanner_crossfade: frames go in with random
// gaps, pixels are compared field by field against a frame predictor kept here.
// Depends on lsx_pkg and the led_scanner_crossfade RTL.
module led_scanner_crossfade_test;

    localparam int LEDS       = lsx_pkg::LED_COUNT;
    localparam int TAIL_STEPS = lsx_pkg::TAIL_LENGTH * 16;
    localparam int TOP_POS    = (LEDS - 1) * 256;
    localparam int DRAIN_WAIT = 40;

    localparam logic [lsx_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int STEP_BY_LEVEL [5] = '{15, 31, 46, 64, 90};

    // Tail falloff per 1/16 LED of distance; everything past the end is dark.
    localparam int FALLOFF_DEPTH = 112;
    localparam logic [7:0] FALLOFF [FALLOFF_DEPTH] = '{
        255, 242, 228, 216, 204, 192, 182, 171, 162, 153, 144, 136, 129, 122, 115, 108,
        102,  97,  91,  86,  81,  77,  73,  69,  65,  61,  58,  55,  52,  49,  46,  43,
         41,  39,  37,  34,  33,  31,  29,  27,  26,  24,  23,  22,  21,  19,  18,  17,
         16,  15,  15,  14,  13,  12,  12,  11,  10,  10,   9,   9,   8,   8,   7,   7,
          7,   6,   6,   6,   5,   5,   5,   4,   4,   4,   4,   3,   3,   3,   3,   3,
          3,   2,   2,   2,   2,   2,   2,   2,   2,   2,   1,   1,   1,   1,   1,   1,
          1,   1,   1,   1,   1,   1,   1,   1,   1,   1,   1,   1,   1,   0,   0,   0
    };

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_valid     = 1'b0;
    logic                              i_restart   = 1'b0;
    logic                              i_ready     = 1'b0;
    logic                              i_cfg_we    = 1'b0;
    logic [lsx_pkg::CFG_IDX_W-1:0]     i_cfg_idx   = '0;
    logic [lsx_pkg::CFG_DATA_W-1:0]    i_cfg_wdata = '0;
    logic                              o_ready;
    logic                              o_valid;
    logic [5:0]                        o_led_index;
    logic [7:0]                        o_red;
    logic [7:0]                        o_green;
    logic [7:0]                        o_blue;
    logic                              o_last;

    led_scanner_crossfade DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_led_index (o_led_index),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Predicted scanner state and register copies.
    int unsigned  scan_pos;
    bit           scan_down;
    int unsigned  brightness;
    int unsigned  shown [3][LEDS];
    logic [7:0]   color [3];
    logic [2:0]   speed;
    logic [7:0]   bright_goal;
    logic [7:0]   fade;
    logic         mirror;

    t_pixel       expected_pixels [$];
    int           error_count    = 0;
    int           frames_sent    = 0;
    int           pixels_checked = 0;
    int           gap_pct        = 0;
    int           stall_pct      = 0;

    function automatic int unsigned ease(input int unsigned cur, goal, rate);
        if (goal >= cur) begin
            return cur + (((goal - cur) * rate + 128) >> 8);
        end
        return cur - (((cur - goal) * rate + 128) >> 8);
    endfunction

    function automatic logic [7:0] drive_level(input int unsigned level, bright);
        longint unsigned v;
        v = (longint'(level) * longint'(bright)) >> 16;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic void reset_scanner_model();
        color       = '{8'd255, 8'd10, 8'd0};
        speed       = 3'd3;
        bright_goal = 8'd60;
        fade        = 8'd51;
        mirror      = 1'b0;
        scan_pos    = 0;
        scan_down   = 1'b0;
        brightness  = 60 * 256;
        foreach (shown[c, i]) shown[c][i] = 0;
    endfunction

    function automatic void record_write(input logic [lsx_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [7:0] data);
        case (idx)
            lsx_pkg::CFG_COLOR_RED:   color[0] = data;
            lsx_pkg::CFG_COLOR_GREEN: color[1] = data;
            lsx_pkg::CFG_COLOR_BLUE:  color[2] = data;
            lsx_pkg::CFG_SPEED_LEVEL: speed = data[2:0];
            lsx_pkg::CFG_TARGET_BRT:  bright_goal = data;
            lsx_pkg::CFG_FADE_RATE:   fade = data;
            lsx_pkg::CFG_FLIP:        mirror = data[0];
            default: ;
        endcase
    endfunction

    // Moves the scanner one frame and queues the pixels that frame produces.
    function automatic void predict_frame(input bit restart);
        int          lvl;
        int          p;
        int unsigned here;
        int unsigned span;
        int unsigned k;
        int unsigned inten;
        logic [7:0]  level [3];
        t_pixel      px;
        lvl = (speed < 1) ? 1 : ((speed > 5) ? 5 : int'(speed));
        if (restart) begin
            scan_pos  = 0;
            scan_down = 1'b0;
        end
        p = int'(scan_pos) + (scan_down ? -STEP_BY_LEVEL[lvl-1] : STEP_BY_LEVEL[lvl-1]);
        if (p >= TOP_POS) begin
            p = TOP_POS;
            scan_down = 1'b1;
        end else if (p <= 0) begin
            p = 0;
            scan_down = 1'b0;
        end
        scan_pos   = p;
        brightness = ease(brightness, int'(bright_goal) * 256, 13);
        for (int i = 0; i < LEDS; i++) begin
            here  = i * 256;
            span  = (here >= scan_pos) ? here - scan_pos : scan_pos - here;
            k     = span >> 4;
            inten = (k < TAIL_STEPS && k < FALLOFF_DEPTH) ? FALLOFF[k] : 0;
            for (int c = 0; c < 3; c++) begin
                shown[c][i] = ease(shown[c][i], int'(color[c]) * inten, fade);
                level[c]    = drive_level(shown[c][i], brightness);
            end
            px.led_index = mirror ? 6'(LEDS - 1 - i) : 6'(i);
            px.red       = level[0];
            px.green     = level[1];
            px.blue      = level[2];
            px.last      = (i == LEDS - 1);
            expected_pixels.push_back(px);
        end
    endfunction

    task automatic compare_field(input string name, input int unsigned want, got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            $display("%0t: pixel with no frame pending, expected none, actual index %0d",
                     $time, o_led_index);
            error_count++;
            return;
        end
        want = expected_pixels.pop_front();
        pixels_checked++;
        compare_field("led_index", want.led_index, o_led_index);
        compare_field("red", want.red, o_red);
        compare_field("green", want.green, o_green);
        compare_field("blue", want.blue, o_blue);
        compare_field("last", want.last, o_last);
    endtask

    // Pixel receiver: checks each accepted transaction and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_pixel();
            end
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Called at a clock edge; returns at the edge where the frame is accepted.
    // Valid stays high afterwards so back-to-back frames need no extra step.
    task automatic send_frame(input bit restart);
        i_cfg_we <= 1'b0;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < gap_pct);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        predict_frame(restart);
        frames_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    // Leaves the write enable high; the next frame drops it.
    task automatic write_reg(input logic [lsx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        record_write(idx, data);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic randomize_settings();
        logic [7:0] data;
        write_reg(lsx_pkg::CFG_COLOR_RED, pick_level());
        write_reg(lsx_pkg::CFG_COLOR_GREEN, pick_level());
        write_reg(lsx_pkg::CFG_COLOR_BLUE, pick_level());
        data = 8'($urandom);
        data[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(1, 5));
        write_reg(lsx_pkg::CFG_SPEED_LEVEL, data);
        write_reg(lsx_pkg::CFG_TARGET_BRT, pick_level());
        write_reg(lsx_pkg::CFG_FADE_RATE, pick_level());
        write_reg(lsx_pkg::CFG_FLIP, 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_UNUSED, 8'($urandom));
        end
    endtask

    task automatic test_reset_defaults();
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    // Every speed code including the clamped ones, then color, brightness, fade
    // and mirroring at their limits, with bits above the speed and flip fields set.
    task automatic test_register_extremes();
        for (int lvl = 0; lvl < 8; lvl++) begin
            wait_idle();
            write_reg(lsx_pkg::CFG_SPEED_LEVEL, {(lvl % 2) ? 5'h1F : 5'h00, 3'(lvl)});
            send_frame(1'b0);
        end
        wait_idle();
        write_reg(lsx_pkg::CFG_COLOR_RED, 8'd255);
        write_reg(lsx_pkg::CFG_COLOR_GREEN, 8'd255);
        write_reg(lsx_pkg::CFG_COLOR_BLUE, 8'd255);
        write_reg(lsx_pkg::CFG_TARGET_BRT, 8'd255);
        write_reg(lsx_pkg::CFG_FADE_RATE, 8'd255);
        send_frame(1'b0);
        send_frame(1'b1);
        // A zero fade rate must hold every shown color where it is.
        wait_idle();
        write_reg(lsx_pkg::CFG_FADE_RATE, 8'd0);
        write_reg(lsx_pkg::CFG_COLOR_RED, 8'd0);
        send_frame(1'b0);
        wait_idle();
        write_reg(lsx_pkg::CFG_FADE_RATE, 8'd255);
        write_reg(lsx_pkg::CFG_COLOR_GREEN, 8'd0);
        write_reg(lsx_pkg::CFG_COLOR_BLUE, 8'd0);
        send_frame(1'b0);
        wait_idle();
        write_reg(lsx_pkg::CFG_TARGET_BRT, 8'd0);
        send_frame(1'b0);
        send_frame(1'b0);
        wait_idle();
        write_reg(lsx_pkg::CFG_FLIP, 8'hFF);
        write_reg(lsx_pkg::CFG_COLOR_RED, 8'd255);
        write_reg(lsx_pkg::CFG_TARGET_BRT, 8'd128);
        send_frame(1'b0);
        wait_idle();
        write_reg(lsx_pkg::CFG_FLIP, 8'hFE);
        write_reg(CFG_UNUSED, 8'hAA);
        send_frame(1'b0);
    endtask

    // Fastest speed long enough to reflect at the top end and then at zero.
    task automatic test_bounce_at_ends();
        wait_idle();
        write_reg(lsx_pkg::CFG_SPEED_LEVEL, 8'hFD);
        write_reg(lsx_pkg::CFG_FADE_RATE, 8'd255);
        write_reg(lsx_pkg::CFG_TARGET_BRT, 8'd255);
        write_reg(lsx_pkg::CFG_COLOR_GREEN, 8'd77);
        send_frame(1'b1);
        repeat (141) send_frame(1'b0);
        send_frame(1'b1);
    endtask

    task automatic test_random_frames(input int segments, input int frames);
        for (int s = 0; s < segments; s++) begin
            wait_idle();
            randomize_settings();
            repeat (frames) send_frame($urandom_range(0, 29) == 0);
        end
    endtask

    initial begin
        reset_scanner_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 8;
        stall_pct = 57;
        test_reset_defaults();
        test_register_extremes();
        test_bounce_at_ends();

        gap_pct   = 57;
        stall_pct = 8;
        test_random_frames(4, 26);

        gap_pct   = 0;
        stall_pct = 0;
        test_random_frames(4, 26);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d frames over directed, end-bounce and random settings;", frames_sent);
        $display("%0d pixels compared, %0d mismatches.", pixels_checked, error_count);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lsx_pkg.sv
hdl/lsx_cfg_regs.sv
hdl/lsx_ctrl.sv
hdl/lsx_dp.sv
hdl/led_scanner_crossfade.sv
hdl/lsx_checker.sv
tb/led_scanner_crossfade_test.sv
